>>> sv/scti_pkg.sv
// Package with the sine knot table and angle constants of the sine/cosine interpolator.
package scti_pkg;

	localparam int unsigned KNOT_COUNT = 91;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned INDEX_W = 7;
	localparam int unsigned FRAC_W = 8;
	localparam int unsigned KNOT_W = 15;
	localparam int unsigned VALUE_W = 16;

	localparam logic [ANGLE_W-1:0] DEG180 = 16'd46080;
	localparam logic [ANGLE_W-1:0] DEG90 = 16'd23040;
	localparam logic [INDEX_W-1:0] LAST_ENTRY = 7'd90;

	typedef enum logic {
		ACT_SINE = 1'b0,
		ACT_COSINE = 1'b1
	} action_t;

	typedef logic [KNOT_W-1:0] knot_t;

	localparam knot_t SINE_KNOTS [0:KNOT_COUNT-1] = '{
		15'h0000, 15'h023c, 15'h0478, 15'h06b3, 15'h08ee,
		15'h0b28, 15'h0d61, 15'h0f9a, 15'h11d1, 15'h1406,
		15'h163a, 15'h186d, 15'h1a9d, 15'h1ccb, 15'h1ef8,
		15'h2121, 15'h2348, 15'h256d, 15'h278e, 15'h29ad,
		15'h2bc8, 15'h2ddf, 15'h2ff4, 15'h3204, 15'h3410,
		15'h3619, 15'h381d, 15'h3a1d, 15'h3c18, 15'h3e0f,
		15'h4001, 15'h41ed, 15'h43d5, 15'h45b7, 15'h4794,
		15'h496c, 15'h4b3d, 15'h4d09, 15'h4ecf, 15'h508e,
		15'h5248, 15'h53fb, 15'h55a7, 15'h574d, 15'h58eb,
		15'h5a83, 15'h5c14, 15'h5d9e, 15'h5f20, 15'h609b,
		15'h620f, 15'h637a, 15'h64df, 15'h663b, 15'h678f,
		15'h68db, 15'h6a1f, 15'h6b5b, 15'h6c8e, 15'h6db9,
		15'h6edb, 15'h6ff5, 15'h7106, 15'h720e, 15'h730d,
		15'h7403, 15'h74f0, 15'h75d4, 15'h76af, 15'h7781,
		15'h7849, 15'h7908, 15'h79bd, 15'h7a69, 15'h7b0c,
		15'h7ba5, 15'h7c34, 15'h7cb9, 15'h7d35, 15'h7da7,
		15'h7e0f, 15'h7e6e, 15'h7ec2, 15'h7f0d, 15'h7f4e,
		15'h7f85, 15'h7fb1, 15'h7fd4, 15'h7fed, 15'h7ffc,
		15'h7fff
	};

endpackage

>>> sv/sine_cosine_table_interpolator_unit.sv
// Pipelined sine/cosine lookup with linear interpolation between table knots.

// The unit accepts one angle per cycle while in_stall is low and returns its sine or cosine as a
// signed Q1.15 value. The angle is folded into the first quadrant, the whole degree selects a
// pair of table knots, and the fraction byte interpolates between them; five register stages
// (cosine mapping, fold, knot lookup, multiply, add and sign) set the depth. Each of the five
// stages moves on when it is empty or when the stage after it moves, so an item is taken
// whenever any stage has room, including while a finished item waits at the output.
module sine_cosine_table_interpolator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [scti_pkg::ANGLE_W-1:0]        angle,
	input  logic                                action,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [scti_pkg::VALUE_W-1:0] value
);
	import scti_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic [ANGLE_W-1:0] ang_s1;
	logic               neg_s1;
	logic [INDEX_W-1:0] idx_s2;
	logic [FRAC_W-1:0]  frac_s2;
	logic               neg_s2;
	knot_t              base_s3;
	logic signed [VALUE_W-1:0] slope_s3;
	logic [FRAC_W-1:0]  frac_s3;
	logic               neg_s3;
	knot_t              base_s4;
	logic signed [VALUE_W+FRAC_W:0] prod_s4;
	logic               neg_s4;
	logic signed [VALUE_W-1:0] value_s5;

	logic [ANGLE_W-1:0] ang_c1;
	logic               neg_c1;
	logic [ANGLE_W-1:0] half_c2;
	logic [ANGLE_W-1:0] fold_c2;
	logic               flip_c2;
	logic [INDEX_W-1:0] nxt_c3;
	logic signed [VALUE_W:0] sum_c5;

	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign out_valid = v_s5;
	assign value = value_s5;

	always_comb begin
		ang_c1 = angle;
		neg_c1 = 1'b0;
		if (action_t'(action) == ACT_COSINE) begin
			if (angle <= DEG90) begin
				ang_c1 = DEG90 - angle;
			end else begin
				ang_c1 = angle - DEG90;
				neg_c1 = 1'b1;
			end
		end
	end

	always_comb begin
		flip_c2 = ang_s1 >= DEG180;
		half_c2 = flip_c2 ? ang_s1 - DEG180 : ang_s1;
		fold_c2 = (half_c2 > DEG90) ? DEG180 - half_c2 : half_c2;
	end

	assign nxt_c3 = (idx_s2 == LAST_ENTRY) ? LAST_ENTRY : idx_s2 + 7'd1;

	assign sum_c5 = signed'({2'b00, base_s4}) + prod_s4[VALUE_W+FRAC_W:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ang_s1 <= ang_c1;
			neg_s1 <= neg_c1;
		end
		if (en_s2) begin
			idx_s2 <= fold_c2[FRAC_W+INDEX_W-1:FRAC_W];
			frac_s2 <= fold_c2[FRAC_W-1:0];
			neg_s2 <= neg_s1 ^ flip_c2;
		end
		if (en_s3) begin
			base_s3 <= SINE_KNOTS[idx_s2];
			slope_s3 <= signed'({1'b0, SINE_KNOTS[nxt_c3]}) - signed'({1'b0, SINE_KNOTS[idx_s2]});
			frac_s3 <= frac_s2;
			neg_s3 <= neg_s2;
		end
		if (en_s4) begin
			base_s4 <= base_s3;
			prod_s4 <= slope_s3 * signed'({1'b0, frac_s3});
			neg_s4 <= neg_s3;
		end
		if (en_s5) begin
			value_s5 <= neg_s4 ? VALUE_W'(-sum_c5) : sum_c5[VALUE_W-1:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("Input stalled while a pipeline stage was free.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value != 16'sh8000))
		else $error("Result outside the Q1.15 range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !(out_valid && !out_stall)) |=>
		($countones({v_s1, v_s2, v_s3, v_s4, v_s5}) ==
		 $past($countones({v_s1, v_s2, v_s3, v_s4, v_s5})) + 1))
		else $error("Accepted item was lost or duplicated in the pipeline.");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the pipelined sine/cosine table interpolator unit.
`timescale 1ns / 100ps

module testbench;

	import scti_pkg::*;

	localparam logic [15:0] ANGLE_90 = 16'd23040;
	localparam logic [15:0] ANGLE_180 = 16'd46080;
	localparam int TOP_KNOT = 90;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_COUNT = 4;
	localparam int PHASE_ITEMS = 170;
	localparam int SEND_IDLE_PCT [0:PHASE_COUNT-1] = '{0, 52, 0, 27};
	localparam int RECV_STALL_PCT [0:PHASE_COUNT-1] = '{0, 0, 52, 27};

	localparam int KNOTS [0:TOP_KNOT] = '{
		'h0000, 'h023c, 'h0478, 'h06b3, 'h08ee, 'h0b28, 'h0d61, 'h0f9a, 'h11d1, 'h1406,
		'h163a, 'h186d, 'h1a9d, 'h1ccb, 'h1ef8, 'h2121, 'h2348, 'h256d, 'h278e, 'h29ad,
		'h2bc8, 'h2ddf, 'h2ff4, 'h3204, 'h3410, 'h3619, 'h381d, 'h3a1d, 'h3c18, 'h3e0f,
		'h4001, 'h41ed, 'h43d5, 'h45b7, 'h4794, 'h496c, 'h4b3d, 'h4d09, 'h4ecf, 'h508e,
		'h5248, 'h53fb, 'h55a7, 'h574d, 'h58eb, 'h5a83, 'h5c14, 'h5d9e, 'h5f20, 'h609b,
		'h620f, 'h637a, 'h64df, 'h663b, 'h678f, 'h68db, 'h6a1f, 'h6b5b, 'h6c8e, 'h6db9,
		'h6edb, 'h6ff5, 'h7106, 'h720e, 'h730d, 'h7403, 'h74f0, 'h75d4, 'h76af, 'h7781,
		'h7849, 'h7908, 'h79bd, 'h7a69, 'h7b0c, 'h7ba5, 'h7c34, 'h7cb9, 'h7d35, 'h7da7,
		'h7e0f, 'h7e6e, 'h7ec2, 'h7f0d, 'h7f4e, 'h7f85, 'h7fb1, 'h7fd4, 'h7fed, 'h7ffc,
		'h7fff
	};

	typedef struct {
		logic [15:0] angle;
		action_t     action;
	} angle_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] angle = '0;
	logic action = ACT_SINE;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] value;

	angle_item_t angle_queue [$];
	angle_item_t next_item;
	logic signed [15:0] predicted_values [$];
	logic signed [15:0] wanted;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatches = 0;

	sine_cosine_table_interpolator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.angle(angle),
		.action(action),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value)
	);

	always #10 clk = ~clk;

	// Folds the angle into the first quadrant and interpolates between neighbouring knots.
	function automatic logic signed [15:0] sine_of(input logic [15:0] ang);
		logic [15:0] folded;
		logic negate;
		int idx;
		int nxt;
		int base;
		int delta;
		int r;
		folded = ang;
		negate = 1'b0;
		if (folded >= ANGLE_180) begin
			folded = folded - ANGLE_180;
			negate = 1'b1;
		end
		if (folded > ANGLE_90)
			folded = ANGLE_180 - folded;
		idx = int'(folded[15:8]);
		nxt = (idx < TOP_KNOT) ? idx + 1 : TOP_KNOT;
		base = KNOTS[idx];
		delta = KNOTS[nxt] - base;
		r = base + ((delta * int'(folded[7:0])) >>> 8);
		return 16'(negate ? -r : r);
	endfunction

	function automatic logic signed [15:0] trig_value(input logic [15:0] ang, input logic act);
		if (act == ACT_SINE)
			return sine_of(ang);
		else if (ang <= ANGLE_90)
			return sine_of(ANGLE_90 - ang);
		else
			return -sine_of(ang - ANGLE_90);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic queue_item(input logic [15:0] ang, input action_t act);
		angle_item_t it;
		it.angle = ang;
		it.action = act;
		angle_queue.push_back(it);
	endtask

	// Most angles are uniform; some cluster round the quadrant and half-turn boundaries.
	task automatic queue_random(input int count);
		int pick;
		logic [15:0] ang;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			if (pick < 2)
				ang = ANGLE_90 - 16'd256 + 16'($urandom_range(512));
			else if (pick < 4)
				ang = ANGLE_180 - 16'd256 + 16'($urandom_range(512));
			else
				ang = 16'($urandom);
			queue_item(ang, action_t'($urandom_range(1)));
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (angle_queue.size() != 0 || in_valid || predicted_values.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predicted_values.push_back(trig_value(angle, action));
			if (!in_valid || !in_stall) begin
				if (angle_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = angle_queue.pop_front();
					angle <= next_item.angle;
					action <= next_item.action;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_served + 1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_values.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d", value));
			end else begin
				wanted = predicted_values.pop_front();
				if (value !== wanted)
					report_mismatch($sformatf("value=%0d, predicted %0d", value, wanted));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_item(16'h0000, ACT_SINE);
		queue_item(16'h0000, ACT_COSINE);
		queue_item(16'h0001, ACT_SINE);
		queue_item(16'h00ff, ACT_SINE);
		queue_item(16'h2d80, ACT_SINE);
		queue_item(16'h59ff, ACT_SINE);
		queue_item(ANGLE_90, ACT_SINE);
		queue_item(ANGLE_90, ACT_COSINE);
		queue_item(16'h5a01, ACT_SINE);
		queue_item(16'h5a01, ACT_COSINE);
		queue_item(16'h5aff, ACT_SINE);
		queue_item(16'h8000, ACT_SINE);
		queue_item(16'h8000, ACT_COSINE);
		queue_item(16'hb3ff, ACT_SINE);
		queue_item(16'hb3ff, ACT_COSINE);
		queue_item(ANGLE_180, ACT_SINE);
		queue_item(ANGLE_180, ACT_COSINE);
		queue_item(16'hb401, ACT_SINE);
		queue_item(16'hd800, ACT_SINE);
		queue_item(16'hd800, ACT_COSINE);
		queue_item(16'hffff, ACT_SINE);
		queue_item(16'hffff, ACT_COSINE);
		queue_item(16'h5555, ACT_COSINE);
		queue_item(16'haaaa, ACT_COSINE);
		wait_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			send_idle_pct = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			queue_random(PHASE_ITEMS);
			// The output is held back for a long stretch while angles keep arriving.
			if (p == 0)
				hold_asked = hold_asked + 1;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[sine_cosine_table_interpolator_unit] OK");
		else
			$display("[sine_cosine_table_interpolator_unit] ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("[sine_cosine_table_interpolator_unit] ERROR");
		$finish;
	end

endmodule
